// ----- rtl/bounded_deque_sorted_list_top_macros.svh -----
// Assertion macros shared by the bounded deque RTL.
`ifndef BOUNDED_DEQUE_SORTED_LIST_TOP_MACROS_SVH
`define BOUNDED_DEQUE_SORTED_LIST_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BDSL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bdsl assertion failed");
`define BDSL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bdsl implication failed");
`define BDSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bdsl next-cycle check failed");
`else
`define BDSL_ASSERT(lbl, clk, rstn, prop)
`define BDSL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BDSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/bdsl_pkg.sv -----
// Package with the types and constants of the bounded deque.
`default_nettype none
package bdsl_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_ORD   = 3'd2,
    REQ_POP_FRONT = 3'd3,
    REQ_POP_BACK  = 3'd4,
    REQ_REMOVE    = 3'd5,
    REQ_SEARCH    = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FIND  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic find;
    logic apply;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/bdsl_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
`default_nettype none
`include "bounded_deque_sorted_list_top_macros.svh"
module bdsl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output bdsl_pkg::cmd_t     cmd_o,
  output logic               done_o
);

  bdsl_pkg::state_e state_q, state_d;
  logic             done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdsl_pkg::ST_IDLE: begin
        if (start) begin
          state_d = bdsl_pkg::ST_FIND;
        end
      end
      bdsl_pkg::ST_FIND: begin
        state_d = bdsl_pkg::ST_APPLY;
      end
      bdsl_pkg::ST_APPLY: begin
        state_d = bdsl_pkg::ST_IDLE;
      end
      default: begin
        state_d = bdsl_pkg::ST_IDLE;
      end
    endcase
  end

  assign done_d = (state_q == bdsl_pkg::ST_APPLY);
  assign busy   = (state_q != bdsl_pkg::ST_IDLE);

  assign cmd_o.load  = (state_q == bdsl_pkg::ST_IDLE) && start;
  assign cmd_o.find  = (state_q == bdsl_pkg::ST_FIND);
  assign cmd_o.apply = (state_q == bdsl_pkg::ST_APPLY);
  assign done_o      = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdsl_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  `BDSL_ASSERT_NEXT(a_start_to_find, clk_i, rst_ni, start && !busy, state_q == bdsl_pkg::ST_FIND)
  `BDSL_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)

endmodule
`default_nettype wire

// ----- rtl/bdsl_dp.sv -----
// Datapath: the entry cells, the parallel compare, the shifts and the result registers.
`default_nettype none
`include "bounded_deque_sorted_list_top_macros.svh"
module bdsl_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bdsl_pkg::cmd_t                      cmd_i,
  input  wire logic [bdsl_pkg::REQ_W-1:0]          req_type_i,
  input  wire logic signed [bdsl_pkg::VAL_W-1:0]   value_i,
  output logic signed [bdsl_pkg::VAL_W-1:0]        result_value_o,
  output logic [bdsl_pkg::STAT_W-1:0]              status_o,
  output logic [bdsl_pkg::CNT_W-1:0]               count_o
);

  localparam int CAP   = bdsl_pkg::CAPACITY;
  localparam int CNT_W = bdsl_pkg::CNT_W;
  localparam int VAL_W = bdsl_pkg::VAL_W;

  // Request latched at the transfer.
  logic [bdsl_pkg::REQ_W-1:0]  req_q;
  logic signed [VAL_W-1:0]     value_q;

  logic signed [VAL_W-1:0]     cells_q [CAP];
  logic signed [VAL_W-1:0]     cells_d [CAP];
  logic [CNT_W-1:0]            count_q, count_d;

  // Decisions taken in the find cycle.
  logic [CNT_W-1:0]            pos_q, pos_d;
  logic                        ins_q, ins_d;
  logic                        rem_q, rem_d;
  logic signed [VAL_W-1:0]     res_q, res_d;
  bdsl_pkg::stat_e             stat_q, stat_d;

  logic [CAP-1:0]              live, eq_v, ge_v, last_v, tail_le_v;
  logic signed [VAL_W-1:0]     tail_val;
  logic [CNT_W-1:0]            first_eq, first_ge;
  logic                        full, empty;

  // Every cell is compared against the request value in parallel.
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAP; i++) begin
      live[i]      = CNT_W'(i) < count_q;
      eq_v[i]      = live[i] && (cells_q[i] == value_q);
      ge_v[i]      = live[i] && (cells_q[i] >= value_q);
      last_v[i]    = live[i] && (CNT_W'(i + 1) == count_q);
      tail_le_v[i] = last_v[i] && (cells_q[i] <= value_q);
      tail_val     = tail_val | (last_v[i] ? cells_q[i] : '0);
    end
  end

  always_comb begin
    first_eq = count_q;
    first_ge = count_q;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (eq_v[i]) begin
        first_eq = CNT_W'(i);
      end
      if (ge_v[i]) begin
        first_ge = CNT_W'(i);
      end
    end
  end

  assign full  = (count_q == CNT_W'(CAP));
  assign empty = (count_q == '0);

  always_comb begin
    pos_d  = '0;
    ins_d  = 1'b0;
    rem_d  = 1'b0;
    res_d  = '0;
    stat_d = bdsl_pkg::STAT_OK;
    case (req_q)
      bdsl_pkg::REQ_INS_FRONT,
      bdsl_pkg::REQ_INS_BACK,
      bdsl_pkg::REQ_INS_ORD: begin
        if (full) begin
          stat_d = bdsl_pkg::STAT_FULL;
        end else begin
          ins_d = 1'b1;
          if (req_q == bdsl_pkg::REQ_INS_BACK) begin
            pos_d = count_q;
          end else if (req_q == bdsl_pkg::REQ_INS_ORD) begin
            // At or below the head goes first, at or above the tail goes last.
            if (empty || (cells_q[0] >= value_q)) begin
              pos_d = '0;
            end else if (|tail_le_v) begin
              pos_d = count_q;
            end else begin
              pos_d = first_ge;
            end
          end
        end
      end
      bdsl_pkg::REQ_POP_FRONT,
      bdsl_pkg::REQ_POP_BACK: begin
        if (empty) begin
          stat_d = bdsl_pkg::STAT_EMPTY;
        end else begin
          rem_d = 1'b1;
          if (req_q == bdsl_pkg::REQ_POP_FRONT) begin
            res_d = cells_q[0];
          end else begin
            pos_d = count_q - CNT_W'(1);
            res_d = tail_val;
          end
        end
      end
      bdsl_pkg::REQ_REMOVE: begin
        if (empty) begin
          stat_d = bdsl_pkg::STAT_EMPTY;
        end else if (|eq_v) begin
          rem_d = 1'b1;
          pos_d = first_eq;
          res_d = value_q;
        end else begin
          stat_d = bdsl_pkg::STAT_NOT_FOUND;
        end
      end
      bdsl_pkg::REQ_SEARCH: begin
        stat_d = (|eq_v) ? bdsl_pkg::STAT_OK : bdsl_pkg::STAT_NOT_FOUND;
      end
      default: begin
        stat_d = bdsl_pkg::STAT_OK;
      end
    endcase
  end

  // Each cell takes its neighbour's value when the list opens or closes around it.
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    always_comb begin
      cells_d[g] = cells_q[g];
      if (ins_q) begin
        if (CNT_W'(g) == pos_q) begin
          cells_d[g] = value_q;
        end else if (CNT_W'(g) > pos_q) begin
          if (g > 0) begin
            cells_d[g] = cells_q[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (rem_q) begin
        if ((CNT_W'(g) >= pos_q) && (g < CAP - 1)) begin
          cells_d[g] = cells_q[(g < CAP - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_q) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_q) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      value_q <= value_i;
    end
    if (cmd_i.find) begin
      pos_q  <= pos_d;
      ins_q  <= ins_d;
      rem_q  <= rem_d;
      res_q  <= res_d;
      stat_q <= stat_d;
    end
    if (cmd_i.apply) begin
      for (int i = 0; i < CAP; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_d;
    end
  end

  assign result_value_o = res_q;
  assign status_o       = stat_q;
  assign count_o        = count_q;

  `BDSL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAP))
  `BDSL_ASSERT_IMP(a_full_status, clk_i, rst_ni, cmd_i.apply && (stat_q == bdsl_pkg::STAT_FULL), count_q == CNT_W'(CAP))
  `BDSL_ASSERT_IMP(a_single_edit, clk_i, rst_ni, cmd_i.apply, !(ins_q && rem_q))

endmodule
`default_nettype wire

// ----- rtl/bounded_deque_sorted_list_top.sv -----
// Top level of the bounded deque: controller and datapath.
//
// A request is transferred at a rising edge where start is high and busy is
// low; req_type_i selects one of seven list operations on value_i. The list
// holds up to 16 signed 32-bit entries in order, front first.
// Each request gives exactly one result: done_o is high for a single cycle and
// result_value_o, status_o and count_o are valid in that cycle. The receiver
// cannot hold results off; they are taken at the edge that ends that cycle.
// After the transfer, the find state compares every cell with the value and
// chooses a position, the apply state shifts the cells, and the result is
// then shown while done_o is high.
// busy is high in the find and apply states, so a new request can be taken in
// the same cycle as done_o, but not while the last one is still being worked on.
// Reset empties the list (count zero) and returns the controller to idle; the
// entry cells themselves are not cleared, as only live entries are ever read.
`default_nettype none
module bounded_deque_sorted_list_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [bdsl_pkg::REQ_W-1:0]          req_type_i,
  input  wire logic signed [bdsl_pkg::VAL_W-1:0]   value_i,
  output logic                                     done_o,
  output logic signed [bdsl_pkg::VAL_W-1:0]        result_value_o,
  output logic [bdsl_pkg::STAT_W-1:0]              status_o,
  output logic [bdsl_pkg::CNT_W-1:0]               count_o
);

  bdsl_pkg::cmd_t cmd;

  bdsl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  bdsl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

endmodule
`default_nettype wire

// ----- tb/bdsl_list_sb_pkg.sv -----
// Scoreboard class that predicts and checks the results of the bounded deque.
package bdsl_list_sb_pkg;

  import bdsl_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    stat_e                   status;
    logic [CNT_W-1:0]        count;
  } list_result_t;

  class deque_scoreboard;
    logic signed [VAL_W-1:0] cells[$];
    list_result_t            due[$];
    int unsigned             fails;

    function new();
      fails = 0;
    endfunction

    // Position for an ordered insert: front if at or below the head, back if at
    // or above the tail, otherwise just before the first entry at or above it.
    function int ordered_slot(logic signed [VAL_W-1:0] v);
      if (cells.size() == 0 || v <= cells[0]) return 0;
      if (v >= cells[cells.size()-1]) return cells.size();
      for (int i = 0; i < cells.size(); i++) begin
        if (cells[i] >= v) return i;
      end
      return cells.size();
    endfunction

    // Applies an accepted request to the list copy and queues its result.
    function void note_request(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] v);
      list_result_t r;
      int           slot;
      r.value  = '0;
      r.status = STAT_OK;
      case (req)
        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_ORD: begin
          if (cells.size() >= CAPACITY) begin
            r.status = STAT_FULL;
          end else begin
            if (req == REQ_INS_FRONT) slot = 0;
            else if (req == REQ_INS_BACK) slot = cells.size();
            else slot = ordered_slot(v);
            cells.insert(slot, v);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (cells.size() == 0) r.status = STAT_EMPTY;
          else if (req == REQ_POP_FRONT) r.value = cells.pop_front();
          else r.value = cells.pop_back();
        end
        REQ_REMOVE: begin
          if (cells.size() == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.status = STAT_NOT_FOUND;
            for (int i = 0; i < cells.size(); i++) begin
              if (cells[i] == v) begin
                r.value  = cells[i];
                r.status = STAT_OK;
                cells.delete(i);
                break;
              end
            end
          end
        end
        REQ_SEARCH: begin
          r.status = STAT_NOT_FOUND;
          foreach (cells[i]) begin
            if (cells[i] == v) r.status = STAT_OK;
          end
        end
        default: begin
        end
      endcase
      r.count = CNT_W'(cells.size());
      due.push_back(r);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] value, logic [STAT_W-1:0] status,
                               logic [CNT_W-1:0] count);
      list_result_t exp;
      if (due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("ERROR: result with nothing outstanding: value %0d status %0d count %0d",
                   value, status, count);
        return;
      end
      exp = due.pop_front();
      if (value !== exp.value || status !== exp.status || count !== exp.count) begin
        fails++;
        if (fails <= 10)
          $display("ERROR: expected value %0d status %0d count %0d, got %0d %0d %0d",
                   exp.value, exp.status, exp.count, value, status, count);
      end
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    // A live entry, so that removes and searches often hit.
    function logic signed [VAL_W-1:0] any_entry();
      if (cells.size() == 0) return '0;
      return cells[$urandom_range(0, cells.size()-1)];
    endfunction
  endclass

endpackage

// ----- tb/tb_bounded_deque_sorted_list_top.sv -----
// Testbench top that drives random list requests and checks every result.
module tb_bounded_deque_sorted_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdsl_pkg::*;
  import bdsl_list_sb_pkg::*;

  localparam logic [REQ_W-1:0]        REQ_UNUSED   = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN      = 32'sh8000_0000;
  localparam int                      RANDOM_ITEMS = 650;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [REQ_W-1:0]        req_type_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    done_o;
  logic signed [VAL_W-1:0] result_value_o;
  logic [STAT_W-1:0]       status_o;
  logic [CNT_W-1:0]        count_o;

  deque_scoreboard list_sb;
  bit              no_idle;

  bounded_deque_sorted_list_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) list_sb.check_result(result_value_o, status_o, count_o);
  end

  // One request transfer; start stays high when the next request follows at once.
  task automatic transfer(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= req;
    value_i    <= v;
    do @(posedge clk_i); while (busy);
    list_sb.note_request(req, v);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (list_sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return list_sb.any_entry();
      4, 5:       return $signed($urandom_range(0, 8)) - 4;
      6: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return -1;
          default: return 0;
        endcase
      end
      default:    return $urandom;
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    bit               filling;
    int               r;
    logic [REQ_W-1:0] req;
    list_sb    = new();
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_type_i = '0;
    value_i    = '0;
    no_idle    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list cases first, then inserts around the extremes, then searches, removes and pops.
    transfer(REQ_POP_FRONT, VAL_MAX);
    transfer(REQ_POP_BACK, VAL_MIN);
    transfer(REQ_REMOVE, 0);
    transfer(REQ_SEARCH, 0);
    transfer(REQ_UNUSED, -1);
    transfer(REQ_INS_ORD, 0);
    transfer(REQ_INS_FRONT, VAL_MIN);
    transfer(REQ_INS_BACK, VAL_MAX);
    transfer(REQ_INS_ORD, VAL_MIN);
    transfer(REQ_INS_ORD, VAL_MAX);
    transfer(REQ_INS_ORD, 5);
    transfer(REQ_INS_ORD, -1);
    transfer(REQ_INS_ORD, 0);
    transfer(REQ_SEARCH, 5);
    transfer(REQ_SEARCH, 7);
    transfer(REQ_REMOVE, 6);
    transfer(REQ_REMOVE, 0);
    transfer(REQ_POP_FRONT, 0);
    transfer(REQ_POP_BACK, 0);
    // Fill to capacity, then every insert must be turned away.
    repeat (CAPACITY - 5) transfer(REQ_W'($urandom_range(0, 2)), $urandom);
    transfer(REQ_INS_FRONT, 1);
    transfer(REQ_INS_BACK, 2);
    transfer(REQ_INS_ORD, 3);
    transfer(REQ_UNUSED, 4);
    wait_drained();

    // Alternate fill and drain spells so that both the full and the empty list
    // are reached many times, with some spells free of idle cycles.
    filling = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        filling = !filling;
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i % 150 == 149) wait_drained();
      r = $urandom_range(0, 99);
      if (r < (filling ? 70 : 25)) req = REQ_W'($urandom_range(0, 2));
      else if (r < 97) req = REQ_W'($urandom_range(3, 6));
      else req = REQ_UNUSED;
      transfer(req, pick_value());
    end
    wait_drained();
    repeat (6) @(posedge clk_i);

    if (list_sb.fails == 0 && list_sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
